// ----- hw/rtl/look_at_view_matrix_macros.svh -----
// ----------------------------------------------------------------------------
// Look-at view matrix assertion macros
// Clocked, reset-gated property checks used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication
`define LAV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LAV_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared fixed-point constants, row codes, control and status types, sat32.
// ----------------------------------------------------------------------------
package lav_pkg;

	localparam int Q_FRAC = 16;
	localparam int U_W    = 18;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	typedef enum logic [1:0] {
		ROW_SIDE  = 2'd0,
		ROW_UP    = 2'd1,
		ROW_FWD   = 2'd2,
		ROW_HOMOG = 2'd3
	} row_t;

	typedef struct packed {
		logic en;
		logic valid;
	} lav_ctl_t;

	typedef struct packed {
		logic valid;
		logic ok;
	} lav_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -40'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/lav_norm.sv -----
// ----------------------------------------------------------------------------
// Vector normalizer
// Pipelined 3-vector normalize to Q1.16: magnitude, range shift, sum of
// squares, digit-recurrence square root and per-lane restoring divide.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
	parameter int IN_W = 33,
	parameter int SB_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lav_ctl_t               ctl,
	input  logic signed [IN_W-1:0] vec [3],
	input  logic [SB_W-1:0]        sb_in,
	output lav_stat_t              stat,
	output logic signed [U_W-1:0]  unit [3],
	output logic [SB_W-1:0]        sb_out
);

	localparam int SW      = ($clog2(IN_W) > 5) ? $clog2(IN_W) : 5;
	localparam int PER     = 2;
	localparam int SQ_ST   = 32 / PER;
	localparam int DV_BITS = Q_FRAC + 1;
	localparam int DV_ST   = (DV_BITS + PER - 1) / PER;

	typedef struct packed {
		logic [2:0][30:0]  m;
		logic [2:0]        neg;
		logic              zero;
		logic [SB_W-1:0]   sb;
	} side_t;

	function automatic logic [SW-1:0] msb_pos(input logic [IN_W-1:0] v);
		logic [SW-1:0] p;
		p = '0;
		for (int b = 0; b < IN_W; b++)
			if (v[b]) p = SW'(b);
		return p;
	endfunction

	// magnitudes
	logic [IN_W-1:0] mag_s1 [3];
	logic [2:0]      neg_s1;
	logic [SB_W-1:0] sb_s1;
	logic            v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (ctl.en) v_s1 <= ctl.valid;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][IN_W-1];
				mag_s1[i] <= vec[i][IN_W-1] ? $unsigned(-vec[i]) : $unsigned(vec[i]);
			end
			sb_s1 <= sb_in;
		end
	end

	// maximum
	logic [IN_W-1:0] mag_s2 [3];
	logic [IN_W-1:0] mx_s2;
	logic [2:0]      neg_s2;
	logic [SB_W-1:0] sb_s2;
	logic            v_s2;
	logic [IN_W-1:0] mx01;

	assign mx01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (ctl.en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			mag_s2 <= mag_s1;
			mx_s2  <= (mx01 > mag_s1[2]) ? mx01 : mag_s1[2];
			neg_s2 <= neg_s1;
			sb_s2  <= sb_s1;
		end
	end

	// leading one
	logic [IN_W-1:0] mag_s3 [3];
	logic [SW-1:0]   pos_s3;
	logic            zero_s3;
	logic [2:0]      neg_s3;
	logic [SB_W-1:0] sb_s3;
	logic            v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (ctl.en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			mag_s3  <= mag_s2;
			pos_s3  <= msb_pos(mx_s2);
			zero_s3 <= (mx_s2 == '0);
			neg_s3  <= neg_s2;
			sb_s3   <= sb_s2;
		end
	end

	// range shift: max lands in [2^30, 2^31)
	side_t sd_s4;
	logic  v_s4;
	side_t sd_c4;

	always_comb begin
		logic [IN_W+30:0] w;
		sd_c4      = '0;
		sd_c4.neg  = neg_s3;
		sd_c4.zero = zero_s3;
		sd_c4.sb   = sb_s3;
		for (int i = 0; i < 3; i++) begin
			w = {31'b0, mag_s3[i]};
			if (pos_s3 < SW'(30))
				w = w << (SW'(30) - pos_s3);
			else
				w = w >> (pos_s3 - SW'(30));
			sd_c4.m[i] = w[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (ctl.en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) sd_s4 <= sd_c4;
	end

	// squares
	logic [61:0] sq_s5 [3];
	side_t       sd_s5;
	logic        v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (ctl.en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++)
				sq_s5[i] <= 62'(sd_s4.m[i]) * 62'(sd_s4.m[i]);
			sd_s5 <= sd_s4;
		end
	end

	// sum of squares
	logic [63:0] sum_s6;
	side_t       sd_s6;
	logic        v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (ctl.en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sum_s6 <= 64'(sq_s5[0]) + 64'(sq_s5[1]) + 64'(sq_s5[2]);
			sd_s6  <= sd_s5;
		end
	end

	// square root, two result bits per stage
	logic [63:0] sqn_s   [SQ_ST+1];
	logic [34:0] sqrem_s [SQ_ST+1];
	logic [31:0] sqrt_s  [SQ_ST+1];
	side_t       sqsd_s  [SQ_ST+1];
	logic        sqv_s   [SQ_ST+1];

	assign sqn_s[0]   = sum_s6;
	assign sqrem_s[0] = '0;
	assign sqrt_s[0]  = '0;
	assign sqsd_s[0]  = sd_s6;
	assign sqv_s[0]   = v_s6;

	for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
		logic [63:0] n_c;
		logic [34:0] r_c;
		logic [31:0] q_c;

		always_comb begin
			logic [63:0] n;
			logic [34:0] r;
			logic [34:0] r2;
			logic [34:0] t;
			logic [31:0] q;
			n = sqn_s[k];
			r = sqrem_s[k];
			q = sqrt_s[k];
			for (int j = 0; j < PER; j++) begin
				r2 = {r[32:0], n[63:62]};
				t  = {1'b0, q, 2'b01};
				if (r2 >= t) begin
					r = r2 - t;
					q = {q[30:0], 1'b1};
				end else begin
					r = r2;
					q = {q[30:0], 1'b0};
				end
				n = {n[61:0], 2'b00};
			end
			n_c = n;
			r_c = r;
			q_c = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqv_s[k+1] <= 1'b0;
			else if (ctl.en) sqv_s[k+1] <= sqv_s[k];
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				sqn_s[k+1]   <= n_c;
				sqrem_s[k+1] <= r_c;
				sqrt_s[k+1]  <= q_c;
				sqsd_s[k+1]  <= sqsd_s[k];
			end
		end
	end

	// divide: (m * 2^16 + L/2) / L, quotient below 2^17
	logic [32:0]        dvr_s   [DV_ST+1][3];
	logic [DV_BITS-1:0] dvnum_s [DV_ST+1][3];
	logic [DV_BITS-1:0] dvq_s   [DV_ST+1][3];
	logic [31:0]        dvl_s   [DV_ST+1];
	side_t              dvsd_s  [DV_ST+1];
	logic               dvv_s   [DV_ST+1];
	logic [47:0]        dv_n    [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			dv_n[i] = 48'({sqsd_s[SQ_ST].m[i], 16'b0}) + 48'(sqrt_s[SQ_ST][31:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvv_s[0] <= 1'b0;
		else if (ctl.en) dvv_s[0] <= sqv_s[SQ_ST];
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int i = 0; i < 3; i++) begin
				dvr_s[0][i]   <= 33'(dv_n[i][47:DV_BITS]);
				dvnum_s[0][i] <= dv_n[i][DV_BITS-1:0];
				dvq_s[0][i]   <= '0;
			end
			dvl_s[0]  <= sqrt_s[SQ_ST];
			dvsd_s[0] <= sqsd_s[SQ_ST];
		end
	end

	for (genvar k = 0; k < DV_ST; k++) begin : g_div
		logic [32:0]        r_c   [3];
		logic [DV_BITS-1:0] num_c [3];
		logic [DV_BITS-1:0] q_c   [3];

		always_comb begin
			logic [32:0]        r;
			logic [32:0]        r2;
			logic [32:0]        l33;
			logic [DV_BITS-1:0] num;
			logic [DV_BITS-1:0] q;
			l33 = {1'b0, dvl_s[k]};
			for (int i = 0; i < 3; i++) begin
				r   = dvr_s[k][i];
				num = dvnum_s[k][i];
				q   = dvq_s[k][i];
				for (int j = 0; j < PER; j++) begin
					if (k * PER + j < DV_BITS) begin
						r2 = {r[31:0], num[DV_BITS-1]};
						if (r2 >= l33) begin
							r = r2 - l33;
							q = {q[DV_BITS-2:0], 1'b1};
						end else begin
							r = r2;
							q = {q[DV_BITS-2:0], 1'b0};
						end
						num = {num[DV_BITS-2:0], 1'b0};
					end
				end
				r_c[i]   = r;
				num_c[i] = num;
				q_c[i]   = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvv_s[k+1] <= 1'b0;
			else if (ctl.en) dvv_s[k+1] <= dvv_s[k];
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				dvr_s[k+1]   <= r_c;
				dvnum_s[k+1] <= num_c;
				dvq_s[k+1]   <= q_c;
				dvl_s[k+1]   <= dvl_s[k];
				dvsd_s[k+1]  <= dvsd_s[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			unit[i] = dvsd_s[DV_ST].neg[i] ? -$signed({1'b0, dvq_s[DV_ST][i]})
			                                :  $signed({1'b0, dvq_s[DV_ST][i]});
	end

	assign stat.valid = dvv_s[DV_ST];
	assign stat.ok    = !dvsd_s[DV_ST].zero;
	assign sb_out     = dvsd_s[DV_ST].sb;

endmodule

// ----- hw/rtl/look_at_view_matrix.sv -----
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the Q16.16 4x4 view matrix from eye, center and up, one row per
// output transaction.
// ----------------------------------------------------------------------------
// A transaction on the item channel carries eye, center and up in signed
// Q16.16; it yields four row transactions, row 0 to row 3, last_row marking
// row 3. The first row appears after the item has passed the input register,
// two 32-stage normalizers around the cross and dot product stages and the
// row output register; items enter back to back until the row output holds
// a matrix and s8 the next item, which waits there until row 3 is taken.
// A zero forward or side vector gives the identity matrix with degenerate set.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix import lav_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               row_valid,
	input  logic               row_stall,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               degenerate,
	output logic               last_row
);

	localparam int SB1_W = 192;
	localparam int SB2_W = 151;
	localparam int C_W   = 50;

	logic adv;

	// s1: forward difference
	logic signed [32:0] d_s1   [3];
	logic signed [31:0] eye_s1 [3];
	logic signed [31:0] up_s1  [3];
	logic               v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0]   <= 33'(eye_x) - 33'(center_x);
			d_s1[1]   <= 33'(eye_y) - 33'(center_y);
			d_s1[2]   <= 33'(eye_z) - 33'(center_z);
			eye_s1[0] <= eye_x;
			eye_s1[1] <= eye_y;
			eye_s1[2] <= eye_z;
			up_s1[0]  <= up_x;
			up_s1[1]  <= up_y;
			up_s1[2]  <= up_z;
		end
	end

	// forward axis
	lav_ctl_t              ctl1;
	lav_stat_t             st1;
	logic signed [U_W-1:0] z_n1 [3];
	logic [SB1_W-1:0]      sb1;
	logic signed [31:0]    eye_n1 [3];
	logic signed [31:0]    up_n1  [3];

	assign ctl1 = '{en: adv, valid: v_s1};

	lav_norm #(.IN_W(33), .SB_W(SB1_W)) u_norm_fwd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl1),
		.vec    (d_s1),
		.sb_in  ({eye_s1[0], eye_s1[1], eye_s1[2], up_s1[0], up_s1[1], up_s1[2]}),
		.stat   (st1),
		.unit   (z_n1),
		.sb_out (sb1)
	);

	assign eye_n1[0] = sb1[191:160];
	assign eye_n1[1] = sb1[159:128];
	assign eye_n1[2] = sb1[127:96];
	assign up_n1[0]  = sb1[95:64];
	assign up_n1[1]  = sb1[63:32];
	assign up_n1[2]  = sb1[31:0];

	// s2: up x forward products
	logic signed [C_W-1:0] p_s2   [6];
	logic signed [U_W-1:0] z_s2   [3];
	logic signed [31:0]    eye_s2 [3];
	logic                  ok_s2;
	logic                  v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= st1.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= C_W'(up_n1[1]) * C_W'(z_n1[2]);
			p_s2[1] <= C_W'(up_n1[2]) * C_W'(z_n1[1]);
			p_s2[2] <= C_W'(up_n1[2]) * C_W'(z_n1[0]);
			p_s2[3] <= C_W'(up_n1[0]) * C_W'(z_n1[2]);
			p_s2[4] <= C_W'(up_n1[0]) * C_W'(z_n1[1]);
			p_s2[5] <= C_W'(up_n1[1]) * C_W'(z_n1[0]);
			z_s2    <= z_n1;
			eye_s2  <= eye_n1;
			ok_s2   <= st1.ok;
		end
	end

	// s3: cross product
	logic signed [C_W-1:0] c_s3   [3];
	logic signed [U_W-1:0] z_s3   [3];
	logic signed [31:0]    eye_s3 [3];
	logic                  ok_s3;
	logic                  v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3[0] <= p_s2[0] - p_s2[1];
			c_s3[1] <= p_s2[2] - p_s2[3];
			c_s3[2] <= p_s2[4] - p_s2[5];
			z_s3    <= z_s2;
			eye_s3  <= eye_s2;
			ok_s3   <= ok_s2;
		end
	end

	// side axis
	lav_ctl_t              ctl2;
	lav_stat_t             st2;
	logic signed [U_W-1:0] x_n2 [3];
	logic [SB2_W-1:0]      sb2;
	logic signed [31:0]    eye_n2 [3];
	logic signed [U_W-1:0] z_n2   [3];

	assign ctl2 = '{en: adv, valid: v_s3};

	lav_norm #(.IN_W(C_W), .SB_W(SB2_W)) u_norm_side (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl2),
		.vec    (c_s3),
		.sb_in  ({eye_s3[0], eye_s3[1], eye_s3[2], z_s3[0], z_s3[1], z_s3[2], ok_s3}),
		.stat   (st2),
		.unit   (x_n2),
		.sb_out (sb2)
	);

	assign eye_n2[0] = sb2[150:119];
	assign eye_n2[1] = sb2[118:87];
	assign eye_n2[2] = sb2[86:55];
	assign z_n2[0]   = sb2[54:37];
	assign z_n2[1]   = sb2[36:19];
	assign z_n2[2]   = sb2[18:1];

	// s4: forward x side products
	logic signed [35:0]    q_s4   [6];
	logic signed [U_W-1:0] x_s4   [3];
	logic signed [U_W-1:0] z_s4   [3];
	logic signed [31:0]    eye_s4 [3];
	logic                  ok_s4;
	logic                  v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= st2.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4[0] <= 36'(z_n2[1]) * 36'(x_n2[2]);
			q_s4[1] <= 36'(z_n2[2]) * 36'(x_n2[1]);
			q_s4[2] <= 36'(z_n2[2]) * 36'(x_n2[0]);
			q_s4[3] <= 36'(z_n2[0]) * 36'(x_n2[2]);
			q_s4[4] <= 36'(z_n2[0]) * 36'(x_n2[1]);
			q_s4[5] <= 36'(z_n2[1]) * 36'(x_n2[0]);
			x_s4    <= x_n2;
			z_s4    <= z_n2;
			eye_s4  <= eye_n2;
			ok_s4   <= sb2[0] && st2.ok;
		end
	end

	// s5: up axis, rounded to Q4.16
	logic signed [36:0]    yw   [3];
	logic signed [20:0]    y_s5   [3];
	logic signed [U_W-1:0] x_s5   [3];
	logic signed [U_W-1:0] z_s5   [3];
	logic signed [31:0]    eye_s5 [3];
	logic                  ok_s5;
	logic                  v_s5;

	assign yw[0] = 37'(q_s4[0]) - 37'(q_s4[1]);
	assign yw[1] = 37'(q_s4[2]) - 37'(q_s4[3]);
	assign yw[2] = 37'(q_s4[4]) - 37'(q_s4[5]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				y_s5[i] <= 21'((yw[i] + 37'sd32768) >>> Q_FRAC);
			x_s5   <= x_s4;
			z_s5   <= z_s4;
			eye_s5 <= eye_s4;
			ok_s5  <= ok_s4;
		end
	end

	// s6: row . eye products
	logic signed [52:0]    dp_s6 [3][3];
	logic signed [U_W-1:0] x_s6  [3];
	logic signed [20:0]    y_s6  [3];
	logic signed [U_W-1:0] z_s6  [3];
	logic                  ok_s6;
	logic                  v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				dp_s6[0][j] <= 53'(x_s5[j]) * 53'(eye_s5[j]);
				dp_s6[1][j] <= 53'(y_s5[j]) * 53'(eye_s5[j]);
				dp_s6[2][j] <= 53'(z_s5[j]) * 53'(eye_s5[j]);
			end
			x_s6  <= x_s5;
			y_s6  <= y_s5;
			z_s6  <= z_s5;
			ok_s6 <= ok_s5;
		end
	end

	// s7: dot sums
	logic signed [54:0]    ds_s7 [3];
	logic signed [U_W-1:0] x_s7  [3];
	logic signed [20:0]    y_s7  [3];
	logic signed [U_W-1:0] z_s7  [3];
	logic                  ok_s7;
	logic                  v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				ds_s7[r] <= 55'(dp_s6[r][0]) + 55'(dp_s6[r][1]) + 55'(dp_s6[r][2]);
			x_s7  <= x_s6;
			y_s7  <= y_s6;
			z_s7  <= z_s6;
			ok_s7 <= ok_s6;
		end
	end

	// s8: translation column
	logic signed [38:0]    rnd  [3];
	logic signed [31:0]    t_s8 [3];
	logic signed [U_W-1:0] x_s8 [3];
	logic signed [20:0]    y_s8 [3];
	logic signed [U_W-1:0] z_s8 [3];
	logic                  ok_s8;
	logic                  v_s8;

	always_comb begin
		for (int r = 0; r < 3; r++)
			rnd[r] = 39'((ds_s7[r] + 55'sd32768) >>> Q_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				t_s8[r] <= sat32(-(40'(rnd[r])));
			x_s8  <= x_s7;
			y_s8  <= y_s7;
			z_s8  <= z_s7;
			ok_s8 <= ok_s7;
		end
	end

	// row output
	logic signed [31:0] mat_q [3][4];
	logic               deg_q;
	logic               full_q;
	row_t               row_q;
	logic               take;
	logic               done;
	logic               load;

	assign take = full_q && !row_stall;
	assign done = take && (row_q == ROW_HOMOG);
	assign adv  = !v_s8 || !full_q || done;
	assign load = adv && v_s8;

	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			row_q  <= ROW_SIDE;
		end else if (load) begin
			full_q <= 1'b1;
			row_q  <= ROW_SIDE;
		end else if (done) begin
			full_q <= 1'b0;
		end else if (take) begin
			row_q <= row_t'(2'(row_q) + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			deg_q <= !ok_s8;
			for (int j = 0; j < 3; j++) begin
				mat_q[0][j] <= ok_s8 ? 32'(x_s8[j]) : ((j == 0) ? ONE_Q16 : 32'sd0);
				mat_q[1][j] <= ok_s8 ? 32'(y_s8[j]) : ((j == 1) ? ONE_Q16 : 32'sd0);
				mat_q[2][j] <= ok_s8 ? 32'(z_s8[j]) : ((j == 2) ? ONE_Q16 : 32'sd0);
			end
			for (int r = 0; r < 3; r++)
				mat_q[r][3] <= ok_s8 ? t_s8[r] : 32'sd0;
		end
	end

	always_comb begin
		case (row_q)
			ROW_SIDE: begin
				col0 = mat_q[0][0]; col1 = mat_q[0][1]; col2 = mat_q[0][2]; col3 = mat_q[0][3];
			end
			ROW_UP: begin
				col0 = mat_q[1][0]; col1 = mat_q[1][1]; col2 = mat_q[1][2]; col3 = mat_q[1][3];
			end
			ROW_FWD: begin
				col0 = mat_q[2][0]; col1 = mat_q[2][1]; col2 = mat_q[2][2]; col3 = mat_q[2][3];
			end
			default: begin
				col0 = 32'sd0; col1 = 32'sd0; col2 = 32'sd0; col3 = ONE_Q16;
			end
		endcase
	end

	assign row_valid  = full_q;
	assign row_index  = row_q;
	assign degenerate = deg_q;
	assign last_row   = (row_q == ROW_HOMOG);

	`LAV_ASSERT_IMP(a_stall_full, item_stall, v_s8 && full_q, "input stalled with room to advance")
	`LAV_ASSERT_NXT(a_row_step, row_valid && !row_stall && row_q != ROW_HOMOG, row_valid && (2'(row_q) == 2'($past(row_q)) + 2'd1), "row sequence skipped or repeated")
	`LAV_ASSERT_IMP(a_deg_ident, row_valid && degenerate, col3 == (last_row ? ONE_Q16 : 32'sd0), "degenerate matrix is not identity")
	`LAV_ASSERT_NXT(a_drain, row_valid && !row_stall && row_q == ROW_HOMOG && !v_s8, !row_valid, "row output did not empty after last row")

endmodule

// ----- bench/lav_view_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Look-at view matrix checker
// Watches the item and row channels, computes the expected view matrix rows
// for every accepted item and compares each row transaction field by field.
// ----------------------------------------------------------------------------
module lav_view_checker import lav_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	input  logic               row_valid,
	input  logic               row_stall,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] col0,
	input  logic signed [31:0] col1,
	input  logic signed [31:0] col2,
	input  logic signed [31:0] col3,
	input  logic               degenerate,
	input  logic               last_row,
	output int                 fail_count,
	output int                 rows_pending,
	output int                 degen_rows
);

	typedef struct packed {
		row_t               idx;
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] c3;
		logic               degen;
		logic               last;
	} view_row_t;

	view_row_t matrix_rows_q[$];

	function automatic longint unsigned isqrt_u64(longint unsigned n);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint round_to_q16(longint v);
		longint t;
		t = v + 32768;
		return t >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp_q16(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic bit unit_vector(input longint v[3], output longint u[3]);
		longint unsigned m[3], mx, len, total;
		longint q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0)
			return 0;
		while (mx < (64'd1 << 30)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		while (mx >= (64'd1 << 31)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		total = 0;
		for (int i = 0; i < 3; i++) total += m[i] * m[i];
		len = isqrt_u64(total);
		if (len == 0)
			return 0;
		for (int i = 0; i < 3; i++) begin
			q    = (m[i] * 65536 + len / 2) / len;
			u[i] = v[i] < 0 ? -q : q;
		end
		return 1;
	endfunction

	function automatic void cross_prod(input longint a[3], input longint b[3],
		output longint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	task automatic predict_view_rows();
		longint eye[3], dir[3], fwd[3], up[3], sc[3], side[3], yw[3];
		longint axes[3][3], dot;
		bit ok;
		view_row_t r;
		eye = '{eye_x, eye_y, eye_z};
		dir = '{longint'(eye_x) - center_x, longint'(eye_y) - center_y,
			longint'(eye_z) - center_z};
		up  = '{up_x, up_y, up_z};
		ok = unit_vector(dir, fwd);
		if (ok) begin
			cross_prod(up, fwd, sc);
			ok = unit_vector(sc, side);
		end
		if (ok) begin
			cross_prod(fwd, side, yw);
			for (int j = 0; j < 3; j++) begin
				axes[0][j] = side[j];
				axes[1][j] = round_to_q16(yw[j]);
				axes[2][j] = fwd[j];
			end
		end
		for (int i = 0; i < 4; i++) begin
			r       = '0;
			r.idx   = row_t'(i);
			r.degen = !ok;
			r.last  = (i == 3);
			if (!ok || i == 3) begin
				r.c0 = (i == 0) ? ONE_Q16 : 0;
				r.c1 = (i == 1) ? ONE_Q16 : 0;
				r.c2 = (i == 2) ? ONE_Q16 : 0;
				r.c3 = (i == 3) ? ONE_Q16 : 0;
			end else begin
				dot = 0;
				for (int j = 0; j < 3; j++) dot += axes[i][j] * eye[j];
				r.c0 = clamp_q16(axes[i][0]);
				r.c1 = clamp_q16(axes[i][1]);
				r.c2 = clamp_q16(axes[i][2]);
				r.c3 = clamp_q16(-round_to_q16(dot));
			end
			matrix_rows_q.push_back(r);
		end
	endtask

	task automatic compare_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				exp_v, got_v);
		end
	endtask

	initial begin
		fail_count   = 0;
		rows_pending = 0;
		degen_rows   = 0;
	end

	always @(posedge clk) begin
		view_row_t e;
		if (arst_n) begin
			if (row_valid && !row_stall) begin
				if (matrix_rows_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected row transaction, row %0d", $time, row_index);
				end else begin
					e = matrix_rows_q.pop_front();
					compare_field("row_index", e.idx, row_index);
					compare_field("col0", e.c0, col0);
					compare_field("col1", e.c1, col1);
					compare_field("col2", e.c2, col2);
					compare_field("col3", e.c3, col3);
					compare_field("degenerate", e.degen, degenerate);
					compare_field("last_row", e.last, last_row);
					if (degenerate)
						degen_rows++;
				end
			end
			if (item_valid && !item_stall)
				predict_view_rows();
			rows_pending = matrix_rows_q.size();
		end
	end

endmodule

// ----- bench/tb_look_at_view_matrix.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives directed and random eye/center/up items, then random items in three
// flow-control phases; a side checker predicts every matrix row and counts mismatches.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;
	import lav_pkg::*;

	localparam int RANDOM_ITEMS = 410;
	localparam int WATCHDOG_MAX = 5000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
	logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
	logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
	logic row_valid;
	logic row_stall = 0;
	logic [1:0] row_index;
	logic signed [31:0] col0, col1, col2, col3;
	logic degenerate, last_row;
	int fail_count, rows_pending, degen_rows;
	int send_idle_pct = 17, recv_idle_pct = 85;
	int idle_cycles = 0, items_sent = 0;
	logic watchdog_enable = 0;

	always #5 clk = ~clk;

	look_at_view_matrix u_top (.*);

	lav_view_checker u_checker (.*);

	always @(negedge clk)
		row_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (row_valid && !row_stall))
			idle_cycles <= 0;
		else if (watchdog_enable)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(logic signed [31:0] v[9]);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			@(negedge clk);
		end
		{eye_x, eye_y, eye_z} <= {v[0], v[1], v[2]};
		{center_x, center_y, center_z} <= {v[3], v[4], v[5]};
		{up_x, up_y, up_z} <= {v[6], v[7], v[8]};
		item_valid <= 1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic signed [31:0] pick_coord(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 16)) - 8;
		endcase
	endfunction

	task automatic send_random();
		logic signed [31:0] v[9];
		int kind, special;
		kind = $urandom_range(3) == 0 ? $urandom_range(3) : 1;
		for (int i = 0; i < 9; i++) v[i] = pick_coord($urandom_range(9) == 0 ? 0 : kind);
		special = $urandom_range(19);
		if (special == 0)
			{v[3], v[4], v[5]} = {v[0], v[1], v[2]};
		else if (special == 1)
			for (int i = 0; i < 3; i++) v[6 + i] = (v[i] - v[3 + i]) * 3;
		else if (special == 2)
			{v[6], v[7], v[8]} = '0;
		send_item(v);
	endtask

	task automatic wait_drained();
		item_valid <= 0;
		@(negedge clk);
		while (rows_pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic signed [31:0] d[9];
		repeat (10) @(negedge clk);
		arst_n = 1;
		watchdog_enable = 1;
		@(negedge clk);
		d = '{0, 0, 32'sh0005_0000, 0, 0, 0, 0, ONE_Q16, 0};
		send_item(d);
		d = '{ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16,
			0, ONE_Q16, 0};
		send_item(d);
		d = '{0, 0, ONE_Q16, 0, 0, 0, 0, 0, 32'sh0003_0000};
		send_item(d);
		d = '{0, 0, ONE_Q16, 0, 0, 0, 0, 0, 0};
		send_item(d);
		d = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0};
		send_item(d);
		d = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF};
		send_item(d);
		d = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
		send_item(d);
		d = '{-1, -1, -1, 0, 0, 0, 1, 0, 0};
		send_item(d);
		d = '{32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, 0, 0, 32'sh7FFF_FFFF};
		send_item(d);
		d = '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h5555_5555,
			32'hAAAA_AAAA, 32'hFFFF_0000, 32'h0000_FFFF, 32'h1234_5678};
		send_item(d);
		for (int i = 0; i < 10; i++) send_random();
		wait_drained();
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 85 : 0;
			recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 17 : 0;
			for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
				send_random();
				if (i == 40)
					wait_drained();
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d items (directed extremes, degenerate eye/up, random Q16.16);",
			items_sent);
		$display("checked every row, %0d of them degenerate identity rows.", degen_rows);
		if (fail_count == 0 && rows_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lav_pkg.sv
hw/rtl/lav_norm.sv
hw/rtl/look_at_view_matrix.sv
bench/lav_view_checker.sv
bench/tb_look_at_view_matrix.sv
